FILE: hdl/fixed_point_q24_8_alu_top_macros.svh
// Assertion macros for the Q24.8 ALU top level.
// Used by fixed_point_q24_8_alu_top.sv; expects clk and arst_n in scope.
`ifndef FIXED_POINT_Q24_8_ALU_TOP_MACROS_SVH
`define FIXED_POINT_Q24_8_ALU_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset
`define FPA_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

// Next-cycle implication, disabled during reset
`define FPA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

FILE: hdl/fpa_pkg.sv
// Shared types and constants for the Q24.8 fixed-point ALU.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package fpa_pkg;

	localparam int DATA_W        = 32;
	localparam int FRAC_BITS_DEF = 8;

	typedef enum logic [3:0] {
		OP_ADD    = 4'd0,
		OP_SUB    = 4'd1,
		OP_MUL    = 4'd2,
		OP_DIV    = 4'd3,
		OP_GT     = 4'd4,
		OP_GE     = 4'd5,
		OP_LT     = 4'd6,
		OP_LE     = 4'd7,
		OP_EQ     = 4'd8,
		OP_NE     = 4'd9,
		OP_MIN    = 4'd10,
		OP_MAX    = 4'd11,
		OP_INC    = 4'd12,
		OP_DEC    = 4'd13,
		OP_TO_INT = 4'd14,
		OP_FR_INT = 4'd15
	} op_t;

	typedef struct packed {
		logic [3:0]              req_type;
		logic signed [DATA_W-1:0] operand_a;
		logic signed [DATA_W-1:0] operand_b;
	} fpa_req_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] result_value;
		logic                     compare_true;
		logic                     divide_by_zero;
	} fpa_rsp_t;

	// Sideband that rides alongside the arithmetic units
	typedef struct packed {
		op_t               op;
		logic [DATA_W-1:0] result;
		logic              cmp;
		logic              dz;
		logic              neg;
	} fpa_ctl_t;

endpackage

FILE: hdl/fpa_mul.sv
// Three-stage unsigned magnitude multiplier with rounding and sign restore.
// Depends on fpa_pkg.
`timescale 1ns / 1ps

module fpa_mul
	import fpa_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic              clk,
	input  logic              en,
	input  logic [DATA_W-1:0] mag_a,
	input  logic [DATA_W-1:0] mag_b,
	input  logic              neg,
	output logic [DATA_W-1:0] res
);

	localparam int PROD_W = 2 * DATA_W;
	localparam logic [PROD_W-1:0] HALF = PROD_W'(1) << (FRAC_BITS - 1);

	logic [PROD_W-1:0] prod;
	logic [PROD_W-1:0] prod_s2;
	logic              neg_s2;
	logic [PROD_W-1:0] rsum;
	logic [DATA_W-1:0] rnd_s3;
	logic              neg_s3;
	logic [DATA_W-1:0] res_s4;

	assign prod = PROD_W'(mag_a) * PROD_W'(mag_b);
	// product of two magnitudes is at most 2^62, so the round add cannot carry out
	assign rsum = prod_s2 + HALF;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s2 <= prod;
			neg_s2  <= neg;
			rnd_s3  <= rsum[FRAC_BITS +: DATA_W];
			neg_s3  <= neg_s2;
			res_s4  <= neg_s3 ? (~rnd_s3 + DATA_W'(1)) : rnd_s3;
		end
	end

	assign res = res_s4;

endmodule

FILE: hdl/fpa_div_step.sv
// One registered restoring-division step: one quotient bit per stage.
// Depends on fpa_pkg.
`timescale 1ns / 1ps

module fpa_div_step
	import fpa_pkg::*;
#(
	parameter int NUM_W = DATA_W + FRAC_BITS_DEF
) (
	input  logic              clk,
	input  logic              en,
	input  logic [DATA_W-1:0] rem_prev,
	input  logic [NUM_W-1:0]  numq_prev,
	input  logic [DATA_W-1:0] den_prev,
	output logic [DATA_W-1:0] rem_next,
	output logic [NUM_W-1:0]  numq_next,
	output logic [DATA_W-1:0] den_next
);

	logic [DATA_W:0]   trial;
	logic [DATA_W+1:0] diff;
	logic              ge;
	logic [DATA_W-1:0] rem_s1;
	logic [NUM_W-1:0]  numq_s1;
	logic [DATA_W-1:0] den_s1;

	assign trial = {rem_prev, numq_prev[NUM_W-1]};
	assign diff  = {1'b0, trial} - {2'b00, den_prev};
	assign ge    = ~diff[DATA_W+1];

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s1  <= ge ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
			// numerator bits leave at the top, quotient bits enter at the bottom
			numq_s1 <= {numq_prev[NUM_W-2:0], ge};
			den_s1  <= den_prev;
		end
	end

	assign rem_next  = rem_s1;
	assign numq_next = numq_s1;
	assign den_next  = den_s1;

endmodule

FILE: hdl/fpa_div.sv
// Fully pipelined magnitude divider: (mag_a << FRAC_BITS) / mag_b.
// Depends on fpa_pkg and fpa_div_step.
`timescale 1ns / 1ps

module fpa_div
	import fpa_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic              clk,
	input  logic              en,
	input  logic [DATA_W-1:0] mag_a,
	input  logic [DATA_W-1:0] mag_b,
	output logic [DATA_W-1:0] quo
);

	localparam int NUM_W = DATA_W + FRAC_BITS;

	logic [DATA_W-1:0] rem_w  [0:NUM_W];
	logic [NUM_W-1:0]  numq_w [0:NUM_W];
	logic [DATA_W-1:0] den_w  [0:NUM_W];

	assign rem_w[0]  = '0;
	assign numq_w[0] = {mag_a, {FRAC_BITS{1'b0}}};
	assign den_w[0]  = mag_b;

	for (genvar k = 0; k < NUM_W; k++) begin : g_step
		fpa_div_step #(
			.NUM_W(NUM_W)
		) u_step (
			.clk      (clk),
			.en       (en),
			.rem_prev (rem_w[k]),
			.numq_prev(numq_w[k]),
			.den_prev (den_w[k]),
			.rem_next (rem_w[k+1]),
			.numq_next(numq_w[k+1]),
			.den_next (den_w[k+1])
		);
	end

	// quotient wraps to the data width
	assign quo = numq_w[NUM_W][DATA_W-1:0];

endmodule

FILE: hdl/fixed_point_q24_8_alu_top.sv
// Top level of the signed Q24.8 fixed-point ALU.
// Depends on fpa_pkg, fpa_mul, fpa_div and fixed_point_q24_8_alu_top_macros.svh.
`timescale 1ns / 1ps
`include "fixed_point_q24_8_alu_top_macros.svh"

// Usage
//  - Request channel (req_valid / req_ready / req): op code and two raw operands.
//  - Response channel (rsp_valid / rsp_ready / rsp): raw result, compare flag,
//    divide-by-zero flag. Exactly one response per request, in request order.
//  - Throughput: one request per cycle for any mix of operations, sustained while the receiver does not stall.
//  - Path: an accepted request (Q24.8 or any FRAC_BITS) goes through the stage registers,
//    then the response register. Every operation takes the same path length; the divider
//    sets it, at one quotient bit per stage over DATA_W + FRAC_BITS stages.
//  - Multiply: 32x32 magnitude product, then round, then sign, three stages.
//  - Simple operations are resolved in the first stage and ride along.
//  - Reset clears the stage valid bits and the response valid flag, so requests in
//    flight are dropped; data registers are not cleared.
//  - Receiver stall: the response register holds. The pipeline keeps taking
//    requests and shifting as a whole until a request reaches the last stage;
//    only then does req_ready fall.
module fixed_point_q24_8_alu_top
	import fpa_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_ready,
	input  fpa_req_t req,
	output logic     rsp_valid,
	input  logic     rsp_ready,
	output fpa_rsp_t rsp
);

	localparam int NUM_W  = DATA_W + FRAC_BITS;
	localparam int LAST   = NUM_W + 1;     // stage where the quotient appears
	localparam int MUL_ST = 4;             // stage where the product appears
	localparam logic signed [DATA_W-1:0] TOINT_BIAS = DATA_W'((1 << FRAC_BITS) - 1);

	// Stage 0: decode and the simple operations
	op_t                      op;
	logic signed [DATA_W-1:0] a;
	logic signed [DATA_W-1:0] b;
	logic [DATA_W-1:0]        ua;
	logic [DATA_W-1:0]        ub;
	logic signed [DATA_W-1:0] a_bias;
	logic                     lt;
	logic                     gt;
	logic                     eq;
	logic [DATA_W-1:0]        res0;
	logic                     cmp0;
	fpa_ctl_t                 ctl0;

	// Pipeline
	logic              vld_s [1:LAST];
	fpa_ctl_t          ctl_s [1:LAST];
	fpa_ctl_t          ctl_mul;
	logic [DATA_W-1:0] mag_a_s1;
	logic [DATA_W-1:0] mag_b_s1;
	logic [DATA_W-1:0] mul_res;
	logic [DATA_W-1:0] quo;
	logic              adv;
	logic              out_load;

	// Output register
	logic              rsp_valid_q;
	fpa_rsp_t          rsp_q;
	logic [DATA_W-1:0] fin_res;

	assign op = op_t'(req.req_type);
	assign a  = req.operand_a;
	assign b  = req.operand_b;
	assign ua = req.operand_a;
	assign ub = req.operand_b;
	assign lt = a < b;
	assign gt = a > b;
	assign eq = a == b;
	// floor((a + 2^F - 1) / 2^F) for negative a is truncation toward zero
	assign a_bias = a + (a[DATA_W-1] ? TOINT_BIAS : '0);

	always_comb begin
		res0 = '0;
		cmp0 = 1'b0;
		unique case (op) inside
			OP_ADD:    res0 = ua + ub;
			OP_SUB:    res0 = ua - ub;
			OP_GT:     cmp0 = gt;
			OP_GE:     cmp0 = gt | eq;
			OP_LT:     cmp0 = lt;
			OP_LE:     cmp0 = lt | eq;
			OP_EQ:     cmp0 = eq;
			OP_NE:     cmp0 = ~eq;
			OP_MIN:    res0 = lt ? ua : ub;
			OP_MAX:    res0 = gt ? ua : ub;
			OP_INC:    res0 = ua + DATA_W'(1);
			OP_DEC:    res0 = ua - DATA_W'(1);
			OP_TO_INT: res0 = DATA_W'(a_bias >>> FRAC_BITS);
			OP_FR_INT: res0 = ua << FRAC_BITS;
			// multiply and divide are filled in further down
			OP_MUL, OP_DIV: res0 = '0;
			default:   res0 = '0;
		endcase
	end

	assign ctl0.op     = op;
	assign ctl0.result = res0;
	assign ctl0.cmp    = cmp0;
	assign ctl0.dz     = (op == OP_DIV) && (b == '0);
	assign ctl0.neg    = a[DATA_W-1] ^ b[DATA_W-1];

	// Flow control: the response register takes a new item when empty or drained;
	// the pipeline also moves when nothing would fall into the response register.
	assign out_load = ~rsp_valid_q | rsp_ready;
	assign adv      = out_load | ~vld_s[LAST];
	assign req_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int st = 1; st <= LAST; st++) begin
				vld_s[st] <= 1'b0;
			end
		end else if (adv) begin
			vld_s[1] <= req_valid;
			for (int st = 2; st <= LAST; st++) begin
				vld_s[st] <= vld_s[st-1];
			end
		end
	end

	// merge the rounded product as it leaves the multiplier
	always_comb begin
		ctl_mul = ctl_s[MUL_ST];
		if (ctl_s[MUL_ST].op == OP_MUL) begin
			ctl_mul.result = mul_res;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_s[1] <= ctl0;
			mag_a_s1 <= a[DATA_W-1] ? (~ua + DATA_W'(1)) : ua;
			mag_b_s1 <= b[DATA_W-1] ? (~ub + DATA_W'(1)) : ub;
			for (int st = 2; st <= LAST; st++) begin
				if (st == MUL_ST + 1) begin
					ctl_s[st] <= ctl_mul;
				end else begin
					ctl_s[st] <= ctl_s[st-1];
				end
			end
		end
	end

	fpa_mul #(
		.FRAC_BITS(FRAC_BITS)
	) u_mul (
		.clk  (clk),
		.en   (adv),
		.mag_a(mag_a_s1),
		.mag_b(mag_b_s1),
		.neg  (ctl_s[1].neg),
		.res  (mul_res)
	);

	fpa_div #(
		.FRAC_BITS(FRAC_BITS)
	) u_div (
		.clk  (clk),
		.en   (adv),
		.mag_a(mag_a_s1),
		.mag_b(mag_b_s1),
		.quo  (quo)
	);

	// Final select: zero divisor wins, then signed quotient, else carried result
	always_comb begin
		if (ctl_s[LAST].dz) begin
			fin_res = '0;
		end else if (ctl_s[LAST].op == OP_DIV) begin
			fin_res = ctl_s[LAST].neg ? (~quo + DATA_W'(1)) : quo;
		end else begin
			fin_res = ctl_s[LAST].result;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (out_load) begin
			rsp_valid_q <= vld_s[LAST];
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			rsp_q.result_value   <= fin_res;
			rsp_q.compare_true   <= ctl_s[LAST].cmp;
			rsp_q.divide_by_zero <= ctl_s[LAST].dz;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Checks
	`FPA_ASSERT_NOW(a_dz_zero, rsp_valid && rsp.divide_by_zero, rsp.result_value == '0 && !rsp.compare_true, "divide by zero with nonzero result or compare flag")
	`FPA_ASSERT_NOW(a_cmp_zero, rsp_valid && rsp.compare_true, rsp.result_value == '0, "comparison response with nonzero result")
	`FPA_ASSERT_NOW(a_stall_hold, vld_s[LAST] && rsp_valid && !rsp_ready, !req_ready, "pipeline moved while its last request was blocked")
	`FPA_ASSERT_NEXT(a_accept_enter, req_valid && req_ready, vld_s[1], "accepted request missing from first stage")

endmodule
